FILE: rtl/core/sfs_pkg.sv
`timescale 1ns / 1ps
// Package for the streaming substring search block.
// Holds sizing constants, register addresses and the ASCII case-fold helper.
package sfs_pkg;

    localparam int MAX_NEEDLE       = 16;
    localparam int OFFSET_BITS      = 32;
    localparam int NEEDLE_REG_BYTES = 16;
    localparam int LEN_W            = 5;
    localparam int OUT_OFFSET_W     = 32;
    localparam int DATA_W           = 64;
    localparam int ADDR_W           = 5;

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [7:0]             byte_t;

    typedef enum logic [1:0] {
        REG_NEEDLE_LENGTH = 2'd0,
        REG_FOLD_CASE     = 2'd1,
        REG_NEEDLE_LOW    = 2'd2,
        REG_NEEDLE_HIGH   = 2'd3
    } reg_index_t;

    function automatic byte_t fold_byte(input logic fold, input byte_t b);
        byte_t r;
        r = b;
        if (fold && (b >= 8'h41) && (b <= 8'h5A))
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/substring_find_stream.sv
`timescale 1ns / 1ps
// Streaming substring search: top level with register file and match logic.
// Depends on sfs_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one haystack byte per item
//   with carries_byte and last flags. An item with carries_byte low carries
//   no byte; when last is high it ends the haystack, which may be empty.
//   Output channel (out_valid / out_stall) gives one result per haystack,
//   on the item that has last high: found, match_offset, length_overflow.
//   Throughput is one item per cycle unless the receiver stalls; the window
//   compare against the needle is parallel combinational logic between the
//   input register and the result register that holds each result.
//   Reset clears the needle registers, the window, the byte counter and both
//   pipeline valid flags. When the receiver stalls, the held result stays in
//   the output register; one more item waits in the input register, and then
//   in_stall rises until the result is taken.
//   Configure over the APB port only while no haystack is in flight.
module substring_find_stream
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          data_byte,
    input  logic                                carries_byte,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic [sfs_pkg::OUT_OFFSET_W-1:0]    match_offset,
    output logic                                length_overflow,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfs_pkg::ADDR_W-1:0]          paddr,
    input  logic [sfs_pkg::DATA_W-1:0]          pwdata,
    output logic [sfs_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    localparam sfs_pkg::offset_t COUNT_MAX = {sfs_pkg::OFFSET_BITS{1'b1}};

    logic [sfs_pkg::LEN_W-1:0]   needle_length_reg;
    logic                        fold_case_reg;
    logic [63:0]                 needle_low_reg;
    logic [63:0]                 needle_high_reg;
    sfs_pkg::reg_index_t         reg_sel;
    logic                        cfg_write;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    sfs_pkg::byte_t              s1_byte_reg;
    logic                        s1_carries_reg;
    logic                        s1_last_reg;

    sfs_pkg::byte_t              window_reg [sfs_pkg::MAX_NEEDLE];
    sfs_pkg::byte_t              window_next [sfs_pkg::MAX_NEEDLE];
    sfs_pkg::offset_t            count_reg;
    sfs_pkg::offset_t            count_next;
    logic                        seen_reg;
    logic                        seen_next;
    sfs_pkg::offset_t            first_reg;
    sfs_pkg::offset_t            first_next;
    logic                        sat_reg;
    logic                        sat_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        found_reg;
    logic                        found_next;
    logic [sfs_pkg::OUT_OFFSET_W-1:0] offset_reg;
    logic [sfs_pkg::OUT_OFFSET_W-1:0] offset_next;
    logic                        ovf_reg;
    logic                        ovf_next;

    logic                        advance;
    logic                        consume;
    logic                        in_accept;
    logic [sfs_pkg::LEN_W-1:0]   n_used;
    logic [8*sfs_pkg::NEEDLE_REG_BYTES-1:0] needle_vec;
    sfs_pkg::byte_t              shifted [sfs_pkg::MAX_NEEDLE];
    logic                        window_hit;

    // Configuration port
    assign pready    = 1'b1;
    assign reg_sel   = sfs_pkg::reg_index_t'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (reg_sel)
            sfs_pkg::REG_NEEDLE_LENGTH:
                prdata = {{(sfs_pkg::DATA_W-sfs_pkg::LEN_W){1'b0}}, needle_length_reg};
            sfs_pkg::REG_FOLD_CASE:
                prdata = {{(sfs_pkg::DATA_W-1){1'b0}}, fold_case_reg};
            sfs_pkg::REG_NEEDLE_LOW:
                prdata = needle_low_reg;
            sfs_pkg::REG_NEEDLE_HIGH:
                prdata = needle_high_reg;
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_length_reg <= '0;
            fold_case_reg     <= 1'b0;
            needle_low_reg    <= '0;
            needle_high_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                sfs_pkg::REG_NEEDLE_LENGTH: needle_length_reg <= pwdata[sfs_pkg::LEN_W-1:0];
                sfs_pkg::REG_FOLD_CASE:     fold_case_reg     <= pwdata[0];
                sfs_pkg::REG_NEEDLE_LOW:    needle_low_reg    <= pwdata[63:0];
                sfs_pkg::REG_NEEDLE_HIGH:   needle_high_reg   <= pwdata[63:0];
                default:                    fold_case_reg     <= fold_case_reg;
            endcase
        end
    end

    // Handshake
    assign advance   = !(out_valid_reg && out_stall);
    assign consume   = s1_valid_reg && advance;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign out_valid       = out_valid_reg;
    assign found           = found_reg;
    assign match_offset    = offset_reg;
    assign length_overflow = ovf_reg;

    // Window compare
    assign n_used = (int'(needle_length_reg) > sfs_pkg::MAX_NEEDLE) ?
                    sfs_pkg::LEN_W'(sfs_pkg::MAX_NEEDLE) : needle_length_reg;
    assign needle_vec = {needle_high_reg, needle_low_reg};

    always_comb
    begin
        logic [sfs_pkg::LEN_W-1:0] idx;
        sfs_pkg::byte_t            nb;
        window_hit = 1'b1;
        shifted[0] = s1_byte_reg;
        for (int k = 1; k < sfs_pkg::MAX_NEEDLE; k++)
        begin
            shifted[k] = window_reg[k-1];
        end
        for (int k = 0; k < sfs_pkg::MAX_NEEDLE; k++)
        begin
            idx = n_used - sfs_pkg::LEN_W'(k) - sfs_pkg::LEN_W'(1);
            nb  = '0;
            if (int'(idx) < sfs_pkg::NEEDLE_REG_BYTES)
            begin
                nb = needle_vec[{idx[3:0], 3'b000} +: 8];
            end
            if ((k < int'(n_used)) &&
                (sfs_pkg::fold_byte(fold_case_reg, shifted[k]) !=
                 sfs_pkg::fold_byte(fold_case_reg, nb)))
            begin
                window_hit = 1'b0;
            end
        end
    end

    // Per-haystack state and result
    always_comb
    begin
        logic take;
        s1_valid_next  = in_accept ? 1'b1 : (consume ? 1'b0 : s1_valid_reg);
        window_next    = window_reg;
        count_next     = count_reg;
        seen_next      = seen_reg;
        first_next     = first_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && out_stall;
        found_next     = found_reg;
        offset_next    = offset_reg;
        ovf_next       = ovf_reg;
        take           = consume && s1_carries_reg;

        if (take)
        begin
            if (count_reg == COUNT_MAX)
            begin
                sat_next = 1'b1;
            end
            else
            begin
                window_next = shifted;
                count_next  = count_reg + sfs_pkg::offset_t'(1);
                if ((n_used != '0) && !seen_reg && !sat_reg &&
                    (count_reg >= sfs_pkg::offset_t'(n_used - sfs_pkg::LEN_W'(1))) &&
                    window_hit)
                begin
                    seen_next  = 1'b1;
                    first_next = count_reg - sfs_pkg::offset_t'(n_used - sfs_pkg::LEN_W'(1));
                end
            end
        end

        if (consume && s1_last_reg)
        begin
            out_valid_next = 1'b1;
            ovf_next       = sat_next;
            if (n_used == '0)
            begin
                found_next  = 1'b1;
                offset_next = '0;
            end
            else
            begin
                found_next  = seen_next;
                offset_next = seen_next ? sfs_pkg::OUT_OFFSET_W'(first_next) : '0;
            end
            count_next = '0;
            seen_next  = 1'b0;
            first_next = '0;
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            first_reg     <= '0;
            sat_reg       <= 1'b0;
            for (int k = 0; k < sfs_pkg::MAX_NEEDLE; k++)
            begin
                window_reg[k] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            first_reg     <= first_next;
            sat_reg       <= sat_next;
            window_reg    <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg    <= data_byte;
            s1_carries_reg <= carries_byte;
            s1_last_reg    <= last;
        end
        found_reg  <= found_next;
        offset_reg <= offset_next;
        ovf_reg    <= ovf_next;
    end

endmodule

FILE: bench/sfs_match_checker.sv
`timescale 1ns / 1ps
// Result checker for substring_find_stream: tracks the register port and both item channels,
// predicts each search result on its own and compares it with the block. Depends on sfs_pkg.
module sfs_match_checker
    import sfs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [7:0]              data_byte,
    input  logic                    carries_byte,
    input  logic                    last,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic                    found,
    input  logic [OUT_OFFSET_W-1:0] match_offset,
    input  logic                    length_overflow,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    input  logic                    pready,
    output int                      fails,
    output int                      pending,
    output int                      results_seen
);

    typedef struct packed {
        logic                    found;
        logic [OUT_OFFSET_W-1:0] offset;
        logic                    overflow;
    } search_result_t;

    search_result_t   expected_results[$];
    search_result_t   want;
    search_result_t   made;

    byte_t            window [MAX_NEEDLE];
    offset_t          bytes_seen;
    offset_t          first_hit;
    logic             hit_seen;
    logic             count_full;

    logic [LEN_W-1:0] cfg_len;
    logic             cfg_fold;
    logic [63:0]      cfg_low;
    logic [63:0]      cfg_high;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fails++;
    endtask

    function automatic byte_t case_fold(input byte_t b);
        return (cfg_fold && (b inside {[8'h41:8'h5A]})) ? (b ^ 8'h20) : b;
    endfunction

    function automatic byte_t needle_at(input int i);
        if (i < 8)
        begin
            return cfg_low[8*i +: 8];
        end
        else if (i < 16)
        begin
            return cfg_high[8*(i-8) +: 8];
        end
        return 8'h00;
    endfunction

    function automatic int active_len();
        return (int'(cfg_len) > MAX_NEEDLE) ? MAX_NEEDLE : int'(cfg_len);
    endfunction

    task automatic clear_search();
        int i;
        for (i = 0; i < MAX_NEEDLE; i++)
        begin
            window[i] = 8'h00;
        end
        bytes_seen = '0;
        first_hit  = '0;
        hit_seen   = 1'b0;
        count_full = 1'b0;
    endtask

    task automatic absorb_byte(input byte_t b);
        int      n;
        int      i;
        logic    hit;
        offset_t pos;
        n = active_len();
        if (bytes_seen == '1)
        begin
            count_full = 1'b1;
        end
        else
        begin
            for (i = MAX_NEEDLE - 1; i > 0; i--)
            begin
                window[i] = window[i-1];
            end
            window[0]  = b;
            pos        = bytes_seen;
            bytes_seen = bytes_seen + 1'b1;
            if (n != 0 && !hit_seen && !count_full && bytes_seen >= offset_t'(n))
            begin
                hit = 1'b1;
                for (i = 0; i < n; i++)
                begin
                    if (case_fold(window[n-1-i]) != case_fold(needle_at(i)))
                    begin
                        hit = 1'b0;
                    end
                end
                if (hit)
                begin
                    hit_seen  = 1'b1;
                    first_hit = pos + 1'b1 - offset_t'(n);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_search();
            cfg_len  = '0;
            cfg_fold = 1'b0;
            cfg_low  = '0;
            cfg_high = '0;
            expected_results.delete();
            fails        = 0;
            pending      = 0;
            results_seen = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[ADDR_W-1:3]))
                    REG_NEEDLE_LENGTH: cfg_len  = pwdata[LEN_W-1:0];
                    REG_FOLD_CASE:     cfg_fold = pwdata[0];
                    REG_NEEDLE_LOW:    cfg_low  = pwdata;
                    REG_NEEDLE_HIGH:   cfg_high = pwdata;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("result with no search pending (found=%0b offset=%0d)",
                                              found, match_offset));
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_seen++;
                    if (found !== want.found)
                    begin
                        report_mismatch($sformatf("found got %0b expected %0b",
                                                  found, want.found));
                    end
                    if (match_offset !== want.offset)
                    begin
                        report_mismatch($sformatf("match_offset got %0d expected %0d",
                                                  match_offset, want.offset));
                    end
                    if (length_overflow !== want.overflow)
                    begin
                        report_mismatch($sformatf("length_overflow got %0b expected %0b",
                                                  length_overflow, want.overflow));
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                if (carries_byte)
                begin
                    absorb_byte(data_byte);
                end
                if (last)
                begin
                    made.found    = (active_len() == 0) ? 1'b1 : hit_seen;
                    made.offset   = (active_len() != 0 && hit_seen) ?
                                    first_hit[OUT_OFFSET_W-1:0] : '0;
                    made.overflow = count_full;
                    expected_results.push_back(made);
                    clear_search();
                end
            end

            pending = expected_results.size();
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Testbench top for substring_find_stream: resets the block, programs needles over APB,
// streams haystacks under several pacing modes and gives the verdict.
// Depends on sfs_pkg, sfs_match_checker.
module tb;
    import sfs_pkg::*;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 42;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [7:0]              data_byte;
    logic                    carries_byte;
    logic                    last;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    found;
    logic [OUT_OFFSET_W-1:0] match_offset;
    logic                    length_overflow;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    int    fails;
    int    pending;
    int    results_seen;

    int    sender_idle_pct = 0;
    int    stall_pct = 0;
    int    items_sent = 0;
    int    needle_used = 0;
    byte_t needle [MAX_NEEDLE];

    int    len_codes [PHASES] = '{1, 16, 31, 0, 3, 2, 8, 17, 5, 12, 4, 16};

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    substring_find_stream u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .carries_byte    (carries_byte),
        .last            (last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .found           (found),
        .match_offset    (match_offset),
        .length_overflow (length_overflow),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    sfs_match_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .carries_byte    (carries_byte),
        .last            (last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .found           (found),
        .match_offset    (match_offset),
        .length_overflow (length_overflow),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fails           (fails),
        .pending         (pending),
        .results_seen    (results_seen)
    );

    task automatic set_pace(input int mode);
        case (mode)
            1:       begin sender_idle_pct = 50; stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  stall_pct = 50; end
            3:       begin sender_idle_pct = 6;  stall_pct = 6;  end
            default: begin sender_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    task automatic send_item(input byte_t d, input logic has, input logic fin);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= d;
        carries_byte <= has;
        last         <= fin;
        @(negedge clk);
        while (in_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        if (has || fin)
        begin
            items_sent++;
        end
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            send_item(byte_t'(s[i]), 1'b1, i == s.len() - 1);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 8);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_needle(input int len_code, input logic fold);
        logic [63:0] lo;
        logic [63:0] hi;
        int          i;
        for (i = 0; i < 8; i++)
        begin
            lo[8*i +: 8] = needle[i];
            hi[8*i +: 8] = needle[i+8];
        end
        write_reg(REG_NEEDLE_LENGTH, DATA_W'(len_code));
        write_reg(REG_FOLD_CASE, DATA_W'(fold));
        write_reg(REG_NEEDLE_LOW, lo);
        write_reg(REG_NEEDLE_HIGH, hi);
        needle_used = (len_code > MAX_NEEDLE) ? MAX_NEEDLE : len_code;
    endtask

    function automatic byte_t any_letter();
        return byte_t'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
    endfunction

    function automatic byte_t needle_pick();
        byte_t edges [6] = '{8'h00, 8'hFF, 8'h40, 8'h5B, 8'h60, 8'h7B};
        case ($urandom_range(0, 4))
            0:       return byte_t'($urandom_range(0, 255));
            1:       return edges[$urandom_range(0, 5)];
            default: return any_letter();
        endcase
    endfunction

    function automatic byte_t filler_byte();
        case ($urandom_range(0, 3))
            0, 1:    return (needle_used > 0) ? needle[$urandom_range(0, needle_used - 1)]
                                              : byte_t'($urandom_range(0, 255));
            2:       return any_letter();
            default: return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_haystack();
        byte_t hay[$];
        byte_t b;
        int    len;
        int    at;
        int    k;
        int    i;
        logic  marker_end;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 48) : $urandom_range(0, 10);
        for (i = 0; i < len; i++)
        begin
            hay.push_back(filler_byte());
        end
        if (needle_used > 0 && $urandom_range(0, 9) < 7)
        begin
            at = $urandom_range(0, hay.size());
            k  = needle_used - (($urandom_range(0, 4) == 0) ? 1 : 0);
            for (i = 0; i < k; i++)
            begin
                b = needle[i];
                if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(0, 2) == 0)
                begin
                    b = b ^ 8'h20;
                end
                hay.insert(at + i, b);
            end
        end
        marker_end = (hay.size() == 0) || ($urandom_range(0, 9) == 0);
        for (i = 0; i < hay.size(); i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                send_item(byte_t'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_item(hay[i], 1'b1, (i == hay.size() - 1) && !marker_end);
        end
        if (marker_end)
        begin
            send_item(byte_t'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int phase;
        int start_items;
        int i;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        data_byte    <= 8'h00;
        carries_byte <= 1'b0;
        last         <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        for (i = 0; i < MAX_NEEDLE; i++)
        begin
            needle[i] = 8'h00;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty needle: ignored marker, then empty haystack
        set_pace(0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        settle();

        for (i = 0; i < MAX_NEEDLE; i++)
        begin
            needle[i] = byte_t'($urandom_range(0, 255));
        end
        needle[0] = 8'h61;
        needle[1] = 8'h42;
        needle[2] = 8'h63;
        load_needle(3, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_text("aBc");
        send_text("ab");
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h42, 1'b1, 1'b0);
        send_item(8'h63, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        settle();

        // fold case: first match kept, later ones dropped
        write_reg(REG_FOLD_CASE, DATA_W'(1));
        send_text("ABCabc");
        settle();

        for (phase = 0; phase < PHASES; phase++)
        begin
            for (i = 0; i < MAX_NEEDLE; i++)
            begin
                needle[i] = needle_pick();
            end
            load_needle(len_codes[phase], phase % 3 != 0);
            set_pace(phase % 4);
            start_items = items_sent;
            while (items_sent - start_items < ITEMS_PER_PHASE)
            begin
                send_haystack();
            end
            settle();
        end

        $display("Streamed %0d items over %0d needle settings, exact and folded,",
                 items_sent, PHASES + 3);
        $display("four pacing modes; compared %0d search results.", results_seen);
        if (fails == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
